[design/plc_pkg.sv]
// Shared types, codes and constants for the phone line call controller.
// No dependencies; every design file imports this package.
package plc_pkg;

  // Call events
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_INCOMING    = 3'd1;
  localparam logic [2:0] EV_OUTGOING    = 3'd2;
  localparam logic [2:0] EV_ESTABLISHED = 3'd3;
  localparam logic [2:0] EV_CLOSED      = 3'd4;
  localparam logic [2:0] EV_LINK_LOST   = 3'd5;

  // Call states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RINGING = 3'd1;
  localparam logic [2:0] ST_INCALL  = 3'd2;
  localparam logic [2:0] ST_DIALING = 3'd3;
  localparam logic [2:0] ST_ENDING  = 3'd4;

  // Commands
  localparam logic [1:0] CMD_NONE       = 2'd0;
  localparam logic [1:0] CMD_ACCEPT     = 2'd1;
  localparam logic [1:0] CMD_HANGUP     = 2'd2;
  localparam logic [1:0] CMD_SPEED_DIAL = 2'd3;

  // LED modes
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_ON    = 2'd1;
  localparam logic [1:0] LED_BLINK = 2'd2;

  // Channels
  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_TWO  = 2'd2;

  // Hook level encoding: 0 on-hook, 1 off-hook, 2 not yet known
  localparam logic [1:0] HOOK_OFF     = 2'd1;
  localparam logic [1:0] HOOK_UNKNOWN = 2'd2;

  // Debounce counter saturation
  localparam logic [5:0] SETTLE_LIMIT = 6'd50;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ISOLATED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_ON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DIAL  = 3'd4;
  localparam int unsigned CFG_DATA_W = 8;

  typedef struct packed {
    logic [1:0] isolated_channel;
    logic [7:0] ring_on_len;
    logic [7:0] cadence_len;
    logic [5:0] debounce_reads;
    logic       speed_dial_ready;
  } plc_cfg_t;

  typedef struct packed {
    logic       operation;
    logic [2:0] call_event;
    logic       hook_ch1;
    logic       hook_ch2;
    logic       hook_valid;
  } plc_item_t;

  typedef struct packed {
    logic       ring_drive;
    logic [1:0] led_jack_ch2;
    logic [1:0] led_jack_ch1;
    logic       line_feed;
    logic [1:0] selected_channel;
    logic [1:0] command;
    logic [2:0] call_state_out;
  } plc_result_t;

  typedef struct packed {
    logic [2:0] call_state;
    logic [7:0] cadence_phase;
    logic       ring_asserted;
    logic [1:0] settled_hook;
    logic [5:0] settle_count;
    logic [1:0] last_hook;
    logic       baseline_seen;
    logic [1:0] answer_channel;
    logic [3:0] led_levels;     // [3:2] channel 2, [1:0] channel 1
    logic       feed_level;
    logic [1:0] routed_channel;
  } plc_state_t;

  localparam plc_state_t STATE_RESET = '{
    call_state:     ST_IDLE,
    cadence_phase:  8'd0,
    ring_asserted:  1'b0,
    settled_hook:   HOOK_UNKNOWN,
    settle_count:   6'd0,
    last_hook:      HOOK_UNKNOWN,
    baseline_seen:  1'b0,
    answer_channel: CH_TWO,
    led_levels:     4'd0,
    feed_level:     1'b0,
    routed_channel: CH_TWO
  };

endpackage

[design/plc_cfg_regs.sv]
// Configuration register file of the phone line call controller.
// Depends on plc_pkg for register indexes and the config struct.
module plc_cfg_regs
  import plc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output plc_cfg_t              cfg
);

  // Write-only registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.isolated_channel <= 2'd0;
      cfg.ring_on_len      <= 8'd5;
      cfg.cadence_len      <= 8'd12;
      cfg.debounce_reads   <= 6'd3;
      cfg.speed_dial_ready <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ISOLATED:    cfg.isolated_channel <= cfg_data[1:0];
        CFG_RING_ON:     cfg.ring_on_len      <= cfg_data[7:0];
        CFG_RING_PERIOD: cfg.cadence_len      <= cfg_data[7:0];
        CFG_DEBOUNCE:    cfg.debounce_reads   <= cfg_data[5:0];
        CFG_SPEED_DIAL:  cfg.speed_dial_ready <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[design/plc_step.sv]
// Next-state and result logic for one item: event, ring cadence, hook debounce.
// Purely combinational; depends on plc_pkg.
module plc_step
  import plc_pkg::*;
(
  input  plc_cfg_t    cfg,
  input  plc_item_t   item,
  input  plc_state_t  state,
  output plc_state_t  state_next,
  output plc_result_t result
);

  // LED write that respects channel isolation
  function automatic logic [3:0] led_write(input logic [3:0] leds, input logic [1:0] iso_ch,
                                           input logic [1:0] ch, input logic [1:0] mode);
    logic [3:0] r;
    r = leds;
    if (iso_ch == CH_NONE || iso_ch == ch) begin
      if (ch == CH_ONE) r[1:0] = mode;
      else              r[3:2] = mode;
    end
    return r;
  endfunction

  function automatic logic [3:0] leds_both(input logic [3:0] leds, input logic [1:0] iso_ch,
                                           input logic [1:0] mode);
    return led_write(led_write(leds, iso_ch, CH_TWO, mode), iso_ch, CH_ONE, mode);
  endfunction

  function automatic logic [3:0] leds_for(input logic [3:0] leds, input logic [1:0] iso_ch,
                                          input logic [1:0] ch);
    logic [3:0] r;
    r = led_write(leds, iso_ch, CH_TWO, (ch == CH_TWO) ? LED_ON : LED_OFF);
    return led_write(r, iso_ch, CH_ONE, (ch == CH_ONE) ? LED_ON : LED_OFF);
  endfunction

  logic [1:0] iso;
  plc_state_t st;
  logic [1:0] cmd;
  logic       skip_tick;
  logic       ring_live_now;
  logic [7:0] period;
  logic       s1, s2, hk;
  logic [1:0] which;

  assign iso = (cfg.isolated_channel == CH_ONE || cfg.isolated_channel == CH_TWO) ?
               cfg.isolated_channel : CH_NONE;
  assign period = (cfg.cadence_len != 8'd0) ? cfg.cadence_len : 8'd1;

  always_comb begin
    st            = state;
    cmd           = CMD_NONE;
    skip_tick     = 1'b0;
    ring_live_now = 1'b0;
    s1            = 1'b0;
    s2            = 1'b0;
    hk            = 1'b0;
    which         = state.answer_channel;

    // Call event
    case (item.call_event)
      EV_INCOMING: begin
        if (st.call_state == ST_IDLE) begin
          st.call_state    = ST_RINGING;
          st.cadence_phase = 8'd0;
          st.led_levels    = leds_both(st.led_levels, iso, LED_BLINK);
        end
      end
      EV_OUTGOING: begin
        if (st.call_state == ST_IDLE) st.call_state = ST_DIALING;
      end
      EV_ESTABLISHED: begin
        if (st.call_state == ST_ENDING) begin
          cmd = CMD_HANGUP;
        end else begin
          st.call_state    = ST_INCALL;
          st.ring_asserted = 1'b0;
          st.led_levels    = leds_for(st.led_levels, iso, st.answer_channel);
        end
      end
      EV_CLOSED: begin
        st.call_state    = ST_IDLE;
        st.ring_asserted = 1'b0;
        st.led_levels    = leds_both(st.led_levels, iso, LED_OFF);
        st.feed_level    = 1'b0;
        if (iso == CH_NONE) st.routed_channel = CH_TWO;
        st.answer_channel = (iso != CH_NONE) ? iso : CH_TWO;
      end
      EV_LINK_LOST: begin
        st.ring_asserted = 1'b0;
        st.led_levels    = leds_both(st.led_levels, iso, LED_OFF);
        st.feed_level    = 1'b0;
        if (iso == CH_NONE) st.routed_channel = CH_TWO;
        st.call_state    = ST_IDLE;
        st.baseline_seen = 1'b0;
        st.settle_count  = 6'd0;
        st.last_hook     = HOOK_UNKNOWN;
        skip_tick        = 1'b1;
      end
      default: ;
    endcase

    // Poll tick
    if (item.operation && !skip_tick) begin
      // Ring cadence
      if (st.call_state == ST_RINGING) begin
        if (st.cadence_phase >= period) st.cadence_phase = 8'd0;
        ring_live_now    = (st.cadence_phase < cfg.ring_on_len);
        st.ring_asserted = ring_live_now;
        st.cadence_phase = 8'(st.cadence_phase + 8'd1);
        if (st.cadence_phase >= period) st.cadence_phase = 8'd0;
      end else begin
        st.ring_asserted = 1'b0;
        st.cadence_phase = 8'd0;
      end

      // Hook debounce, only while the ring is quiet
      if (!ring_live_now && item.hook_valid) begin
        s1 = (iso == CH_TWO) ? 1'b0 : item.hook_ch1;
        s2 = (iso == CH_ONE) ? 1'b0 : item.hook_ch2;
        which = st.answer_channel;
        if (st.call_state == ST_INCALL || st.call_state == ST_DIALING ||
            st.call_state == ST_ENDING) begin
          hk = (st.answer_channel == CH_ONE) ? s1 : s2;
        end else begin
          hk    = s1 | s2;
          which = s1 ? CH_ONE : (s2 ? CH_TWO : st.answer_channel);
        end

        if ({1'b0, hk} == st.settled_hook) begin
          if (st.settle_count < SETTLE_LIMIT) st.settle_count = 6'(st.settle_count + 6'd1);
        end else begin
          st.settled_hook = {1'b0, hk};
          st.settle_count = 6'd1;
        end

        // Settled change: first one only sets the baseline
        if (st.settle_count == cfg.debounce_reads && st.settled_hook != st.last_hook) begin
          if (!st.baseline_seen) begin
            st.baseline_seen = 1'b1;
          end else if (st.settled_hook == HOOK_OFF) begin
            // Off-hook
            if (st.call_state == ST_RINGING) begin
              st.answer_channel = which;
              if (iso == CH_NONE) st.routed_channel = which;
              st.led_levels    = leds_for(st.led_levels, iso, which);
              cmd              = CMD_ACCEPT;
              st.ring_asserted = 1'b0;
              st.feed_level    = 1'b1;
            end else if (st.call_state == ST_IDLE) begin
              st.answer_channel = which;
              if (iso == CH_NONE) st.routed_channel = which;
              st.feed_level = 1'b1;
              st.led_levels = leds_for(st.led_levels, iso, which);
              if (cfg.speed_dial_ready) begin
                cmd           = CMD_SPEED_DIAL;
                st.call_state = ST_DIALING;
              end
            end else begin
              st.led_levels = leds_for(st.led_levels, iso, st.answer_channel);
            end
          end else begin
            // On-hook
            if (st.call_state == ST_INCALL || st.call_state == ST_DIALING) begin
              cmd              = CMD_HANGUP;
              st.ring_asserted = 1'b0;
              st.led_levels    = leds_both(st.led_levels, iso, LED_OFF);
              st.feed_level    = 1'b0;
              if (iso == CH_NONE) st.routed_channel = CH_TWO;
              st.call_state    = ST_ENDING;
            end else if (st.call_state == ST_IDLE) begin
              st.led_levels = leds_both(st.led_levels, iso, LED_OFF);
              st.feed_level = 1'b0;
              if (iso == CH_NONE) st.routed_channel = CH_TWO;
            end
          end
          st.last_hook = st.settled_hook;
        end
      end
    end

    state_next = st;
    result.ring_drive       = st.ring_asserted;
    result.led_jack_ch2     = st.led_levels[3:2];
    result.led_jack_ch1     = st.led_levels[1:0];
    result.line_feed        = st.feed_level;
    result.selected_channel = st.routed_channel;
    result.command          = cmd;
    result.call_state_out   = st.call_state;
  end

endmodule

[design/phone_line_call_controller.sv]
// Phone line call controller, top level: input register, state, result register.
// Path: each input transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle, limited only by the result register handshake.
// Reset (rst, synchronous, active high) idles the call state and restores config defaults.
// Depends on plc_pkg, plc_cfg_regs and plc_step.
module phone_line_call_controller
  import plc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // operation, call_event[2:0], hook_ch1, hook_ch2,
                                          // hook_valid, zero pad
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,  // ring_drive, led_jack_ch2[1:0], led_jack_ch1[1:0],
                                          // line_feed, selected_channel[1:0], command[1:0],
                                          // call_state_out[2:0], zero pad
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  plc_cfg_t    cfg;
  plc_item_t   in_item;
  logic        in_valid;
  plc_state_t  state, state_next;
  plc_result_t step_result, out_result;
  logic        advance;

  plc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plc_step u_step (
    .cfg        (cfg),
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  // Item moves into the result register when that register is free or drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation  <= s_tdata[0];
      in_item.call_event <= s_tdata[3:1];
      in_item.hook_ch1   <= s_tdata[4];
      in_item.hook_ch2   <= s_tdata[5];
      in_item.hook_valid <= s_tdata[6];
    end
  end

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {3'd0,
                    out_result.call_state_out,
                    out_result.command,
                    out_result.selected_channel,
                    out_result.line_feed,
                    out_result.led_jack_ch1,
                    out_result.led_jack_ch2,
                    out_result.ring_drive};

endmodule

[design/plc_checker.sv]
// Port-level checks for the phone line call controller, bound to the top level.
// Depends on plc_pkg for command and state codes.
module plc_checker
  import plc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic       ring;
  logic       feed;
  logic [1:0] cmd;
  logic [2:0] cstate;

  assign ring   = m_tdata[0];
  assign feed   = m_tdata[5];
  assign cmd    = m_tdata[9:8];
  assign cstate = m_tdata[12:10];

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // Answering keeps the ringing state, drops the ring and raises the feed
  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cmd == CMD_ACCEPT |-> cstate == ST_RINGING && !ring && feed)
    else $error("accept with wrong line levels");

  // Speed dial moves to dialing with the feed active
  a_dial: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cmd == CMD_SPEED_DIAL |-> cstate == ST_DIALING && feed)
    else $error("speed dial with wrong state");

  // Hangup is only reported while ending
  a_hangup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cmd == CMD_HANGUP |-> cstate == ST_ENDING)
    else $error("hangup outside ending state");

  // Ring voltage only while ringing
  a_ring: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ring |-> cstate == ST_RINGING)
    else $error("ring driven outside ringing state");

endmodule

bind phone_line_call_controller plc_checker u_plc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
